// ===== rtl/qslerp_pkg.sv =====
`default_nettype none
package qslerp_pkg;

  localparam int FRAC_BITS        = 15;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int SQRT_STEPS       = 31;
  localparam int DIV_STEPS        = 47;

  localparam logic [30:0] THR_RESET = 31'd10737;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [47:0] ONE_Q30 = 48'sd1073741824;

  typedef struct packed {
    logic [15:0]             t;
    logic [3:0][15:0]        a;
    logic [3:0][16:0]        b;
    logic [32:0]             c;
    logic [30:0]             s;
    logic                    sph;
  } pay_t;

  function automatic logic signed [33:0] atan_q30(input int i);
    logic signed [33:0] r;
    case (i)
      0: r = 34'sh3243F6A8;
      1: r = 34'sh1DAC6705;
      2: r = 34'sh0FADBAFC;
      3: r = 34'sh07F56EA6;
      4: r = 34'sh03FEAB76;
      5: r = 34'sh01FFD55B;
      6: r = 34'sh00FFFAAA;
      7: r = 34'sh007FFF55;
      8: r = 34'sh003FFFEA;
      9: r = 34'sh001FFFFD;
      10: r = 34'sh000FFFFF;
      11: r = 34'sh0007FFFF;
      12: r = 34'sh0003FFFF;
      13: r = 34'sh0001FFFF;
      14: r = 34'sh0000FFFF;
      15: r = 34'sh00007FFF;
      16: r = 34'sh00003FFF;
      17: r = 34'sh00001FFF;
      18: r = 34'sh00000FFF;
      19: r = 34'sh000007FF;
      20: r = 34'sh000003FF;
      21: r = 34'sh000001FF;
      22: r = 34'sh000000FF;
      23: r = 34'sh0000007F;
      24: r = 34'sh0000003F;
      25: r = 34'sh0000001F;
      26: r = 34'sh0000000F;
      27: r = 34'sh00000008;
      28: r = 34'sh00000004;
      29: r = 34'sh00000002;
      30: r = 34'sh00000001;
      default: r = 34'sh0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/quaternion_slerp_core.sv =====
// throughput: one request per cycle unless the result side stalls; the 31-stage square root and the 47-stage
// radix-2 dividers set the depth, together with the two CORDIC pipelines
// a stall on the result side freezes the whole pipeline in place
// reset: synchronous, clears all valid bits and loads lerp_threshold with 10737
`default_nettype none
module quaternion_slerp_core #(
  parameter int CORDIC_STEPS = qslerp_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [15:0]        fraction,
  input  wire logic signed [15:0] from_x,
  input  wire logic signed [15:0] from_y,
  input  wire logic signed [15:0] from_z,
  input  wire logic signed [15:0] from_w,
  input  wire logic signed [15:0] to_x,
  input  wire logic signed [15:0] to_y,
  input  wire logic signed [15:0] to_z,
  input  wire logic signed [15:0] to_w,
  input  wire logic               lerp_threshold_we,
  input  wire logic [30:0]        lerp_threshold,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_x,
  output logic signed [15:0]      out_y,
  output logic signed [15:0]      out_z,
  output logic signed [15:0]      out_w
);

  localparam int N      = CORDIC_STEPS;
  localparam int SQN    = qslerp_pkg::SQRT_STEPS;
  localparam int DVN    = qslerp_pkg::DIV_STEPS;
  localparam int S_DOT  = 2;
  localparam int S_SQ   = 3;
  localparam int S_RT0  = 4;
  localparam int S_AT0  = S_RT0 + SQN;
  localparam int S_ANG  = S_AT0 + N;
  localparam int S_SN0  = S_ANG + 1;
  localparam int S_DV0  = S_SN0 + N;
  localparam int S_MUL  = S_DV0 + DVN;
  localparam int S_OUT  = S_MUL + 1;
  localparam int LAT    = S_OUT + 1;
  localparam int TSH    = 30 - qslerp_pkg::FRAC_BITS;

  logic                 en;
  logic [LAT-1:0]       vld;
  qslerp_pkg::pay_t     pay [LAT];
  qslerp_pkg::pay_t     pnx [LAT];
  qslerp_pkg::pay_t     pin;
  logic [30:0]          thr;

  assign en        = !vld[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= qslerp_pkg::THR_RESET;
    end else if (lerp_threshold_we) begin
      thr <= lerp_threshold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // input stage, fraction clamped to one
  always_comb begin
    pin     = '0;
    pin.t   = (fraction > 16'(1 << qslerp_pkg::FRAC_BITS)) ?
              16'(1 << qslerp_pkg::FRAC_BITS) : fraction;
    pin.a[0] = from_x;
    pin.a[1] = from_y;
    pin.a[2] = from_z;
    pin.a[3] = from_w;
    pin.b[0] = {to_x[15], to_x};
    pin.b[1] = {to_y[15], to_y};
    pin.b[2] = {to_z[15], to_z};
    pin.b[3] = {to_w[15], to_w};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pay[0] <= pin;
    end
  end

  // dot product
  logic signed [32:0] prod [4];
  logic signed [34:0] raw;
  logic [34:0]        raw_abs;
  logic [59:0]        sq;
  logic signed [34:0] diff;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        prod[k] <= $signed(pay[0].a[k]) * $signed(pay[0].b[k]);
      end
    end
  end

  assign raw     = 35'(prod[0]) + 35'(prod[1]) + 35'(prod[2]) + 35'(prod[3]);
  assign raw_abs = raw[34] ? 35'(-raw) : 35'(raw);
  assign diff    = 35'sd1073741824 - $signed({2'b00, pay[S_DOT].c});

  always_ff @(posedge clk) begin
    if (en) begin
      sq <= pay[S_DOT].c[29:0] * pay[S_DOT].c[29:0];
    end
  end

  // square root stages
  logic [60:0] rv [SQN];
  logic [60:0] rr [SQN];

  for (genvar j = 0; j < SQN; j++) begin : g_sqrt
    localparam logic [60:0] BT = 61'(1) << (60 - 2 * j);
    logic [60:0] v_i;
    logic [60:0] r_i;
    logic [61:0] trial;
    if (j == 0) begin : g_first
      assign v_i = (61'(1) << 60) - {1'b0, sq};
      assign r_i = '0;
    end else begin : g_next
      assign v_i = rv[j-1];
      assign r_i = rr[j-1];
    end
    assign trial = {1'b0, r_i} + {1'b0, BT};
    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, v_i} >= trial) begin
          rv[j] <= 61'({1'b0, v_i} - trial);
          rr[j] <= (r_i >> 1) + BT;
        end else begin
          rv[j] <= v_i;
          rr[j] <= r_i >> 1;
        end
      end
    end
  end

  // payload line
  always_comb begin
    pnx[0] = pin;
    for (int k = 1; k < LAT; k++) begin
      pnx[k] = pay[k-1];
      if (k == S_DOT) begin
        pnx[k].c = raw_abs[32:0];
        if (raw[34]) begin
          for (int m = 0; m < 4; m++) begin
            pnx[k].b[m] = 17'(-$signed(pay[k-1].b[m]));
          end
        end
      end
      if (k == S_SQ) begin
        pnx[k].sph = diff > $signed({4'b0000, thr});
      end
      if (k == S_AT0) begin
        pnx[k].s = rr[SQN-1][30:0];
      end
    end
  end

  for (genvar k = 1; k < LAT; k++) begin : g_pay
    always_ff @(posedge clk) begin
      if (en) begin
        pay[k] <= pnx[k];
      end
    end
  end

  // vectoring cordic for the angle
  logic signed [33:0] ax [N];
  logic signed [33:0] ay [N];
  logic signed [33:0] az [N];

  for (genvar i = 0; i < N; i++) begin : g_atan
    logic signed [33:0] x_i;
    logic signed [33:0] y_i;
    logic signed [33:0] z_i;
    if (i == 0) begin : g_first
      assign x_i = $signed({4'b0000, pay[S_AT0-1].c[29:0]});
      assign y_i = $signed({3'b000, rr[SQN-1][30:0]});
      assign z_i = '0;
    end else begin : g_next
      assign x_i = ax[i-1];
      assign y_i = ay[i-1];
      assign z_i = az[i-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!y_i[33]) begin
          ax[i] <= x_i + (y_i >>> i);
          ay[i] <= y_i - (x_i >>> i);
          az[i] <= z_i + qslerp_pkg::atan_q30(i);
        end else begin
          ax[i] <= x_i - (y_i >>> i);
          ay[i] <= y_i + (x_i >>> i);
          az[i] <= z_i - qslerp_pkg::atan_q30(i);
        end
      end
    end
  end

  // angle products
  logic [30:0]        t30a;
  logic [31:0]        tfa;
  logic signed [65:0] pfa;
  logic signed [65:0] pta;
  logic signed [33:0] ang [2];

  assign t30a = 31'(pay[S_ANG-1].t) << TSH;
  assign tfa  = 32'd1073741824 - {1'b0, t30a};
  assign pfa  = $signed(tfa) * az[N-1];
  assign pta  = $signed({1'b0, t30a}) * az[N-1];

  always_ff @(posedge clk) begin
    if (en) begin
      ang[0] <= 34'(pfa >>> 30);
      ang[1] <= 34'(pta >>> 30);
    end
  end

  // rotation cordic for both sines, then division by sin(w)
  logic signed [33:0] sx [2][N];
  logic signed [33:0] sy [2][N];
  logic signed [33:0] sz [2][N];
  logic [30:0]        dr [2][DVN];
  logic [46:0]        dn [2][DVN];
  logic [46:0]        dq [2][DVN];
  logic               dsg [2][DVN];
  logic signed [47:0] wq [2];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    for (genvar i = 0; i < N; i++) begin : g_sin
      logic signed [33:0] x_i;
      logic signed [33:0] y_i;
      logic signed [33:0] z_i;
      if (i == 0) begin : g_first
        assign x_i = qslerp_pkg::CORDIC_GAIN;
        assign y_i = '0;
        assign z_i = ang[l];
      end else begin : g_next
        assign x_i = sx[l][i-1];
        assign y_i = sy[l][i-1];
        assign z_i = sz[l][i-1];
      end
      always_ff @(posedge clk) begin
        if (en) begin
          if (!z_i[33]) begin
            sx[l][i] <= x_i - (y_i >>> i);
            sy[l][i] <= y_i + (x_i >>> i);
            sz[l][i] <= z_i - qslerp_pkg::atan_q30(i);
          end else begin
            sx[l][i] <= x_i + (y_i >>> i);
            sy[l][i] <= y_i - (x_i >>> i);
            sz[l][i] <= z_i + qslerp_pkg::atan_q30(i);
          end
        end
      end
    end

    logic [33:0] mag;
    logic [63:0] num;
    assign mag = sy[l][N-1][33] ? 34'(-sy[l][N-1]) : 34'(sy[l][N-1]);
    assign num = {mag, 30'd0};

    for (genvar j = 0; j < DVN; j++) begin : g_div
      logic [30:0] r_i;
      logic [46:0] n_i;
      logic [46:0] q_i;
      logic        g_i;
      logic [31:0] trial;
      logic        ge;
      if (j == 0) begin : g_first
        assign r_i = 31'(num[63:47]);
        assign n_i = num[46:0];
        assign q_i = '0;
        assign g_i = sy[l][N-1][33];
      end else begin : g_next
        assign r_i = dr[l][j-1];
        assign n_i = dn[l][j-1];
        assign q_i = dq[l][j-1];
        assign g_i = dsg[l][j-1];
      end
      assign trial = {r_i, n_i[46]};
      assign ge    = trial >= {1'b0, pay[S_DV0+j-1].s};
      always_ff @(posedge clk) begin
        if (en) begin
          dr[l][j]  <= ge ? 31'(trial - {1'b0, pay[S_DV0+j-1].s}) : 31'(trial);
          dn[l][j]  <= n_i << 1;
          dq[l][j]  <= {q_i[45:0], ge};
          dsg[l][j] <= g_i;
        end
      end
    end

    assign wq[l] = dsg[l][DVN-1] ? -$signed({1'b0, dq[l][DVN-1]})
                                 : $signed({1'b0, dq[l][DVN-1]});
  end

  // weighted sum
  logic               sel;
  logic [30:0]        t30m;
  logic signed [47:0] wf;
  logic signed [47:0] wt;
  logic signed [64:0] mf [4];
  logic signed [64:0] mt [4];
  logic signed [15:0] ores [4];

  assign t30m = 31'(pay[S_MUL-1].t) << TSH;
  assign sel  = pay[S_MUL-1].sph && (pay[S_MUL-1].s != '0);
  assign wf   = sel ? wq[0] : qslerp_pkg::ONE_Q30 - $signed({17'd0, t30m});
  assign wt   = sel ? wq[1] : $signed({17'd0, t30m});

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        mf[k] <= $signed(pay[S_MUL-1].a[k]) * wf;
        mt[k] <= $signed(pay[S_MUL-1].b[k]) * wt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        if (((66'(mf[k]) + 66'(mt[k]) + 66'sd536870912) >>> 30) > 66'sd32767) begin
          ores[k] <= 16'sh7FFF;
        end else if (((66'(mf[k]) + 66'(mt[k]) + 66'sd536870912) >>> 30) < -66'sd32768) begin
          ores[k] <= 16'sh8000;
        end else begin
          ores[k] <= 16'((66'(mf[k]) + 66'(mt[k]) + 66'sd536870912) >>> 30);
        end
      end
    end
  end

  assign out_x = ores[0];
  assign out_y = ores[1];
  assign out_z = ores[2];
  assign out_w = ores[3];

  a_rst_clears : assert property (@(posedge clk) rst |=> !out_valid)
    else $error("valid left after reset");

  a_stall_holds : assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline moved during stall");

  a_div_range : assert property (@(posedge clk) disable iff (rst)
    (vld[S_DV0-1] && pay[S_DV0-1].sph) |-> (pay[S_DV0-1].s >= 31'd32768))
    else $error("sine divisor too small on spherical path");

endmodule
`default_nettype wire
